/* hw/rtl/rotation_matrix_to_euler_degrees_defines.svh */
// Assertion macros for the rotation matrix to Euler angle converter.
// Included by the top level only; expects clk and rst in scope.
`ifndef ROTATION_MATRIX_TO_EULER_DEGREES_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_DEGREES_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RMTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rmte_pkg.sv */
// Shared types, constants and the CORDIC angle table for the Euler converter.
// No dependencies.
package rmte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int SQRT_STEPS        = 16;
  localparam int IN_W              = 16;
  localparam int OP_W              = 17;  // operand width after negation
  localparam int THR_W             = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd16382;
  localparam int ANG_LIMIT         = 23040;
  localparam int PITCH_LIMIT       = 11520;
  localparam int ONE_Q14           = 16384;

  typedef struct packed {
    logic locked;
    logic clamped;
  } flags_t;

  typedef struct packed {
    logic signed [OP_W-1:0] s;
    logic signed [OP_W-1:0] roll_y;
    logic signed [OP_W-1:0] roll_x;
    logic signed [OP_W-1:0] yaw_y;
    logic signed [OP_W-1:0] yaw_x;
    flags_t                 flags;
  } side_t;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic logic [21:0] atan_q16(input int i);
    logic [21:0] r;
    case (i)
      0:  r = 22'd2949120;
      1:  r = 22'd1740967;
      2:  r = 22'd919879;
      3:  r = 22'd466945;
      4:  r = 22'd234379;
      5:  r = 22'd117304;
      6:  r = 22'd58666;
      7:  r = 22'd29335;
      8:  r = 22'd14668;
      9:  r = 22'd7334;
      10: r = 22'd3667;
      11: r = 22'd1833;
      12: r = 22'd917;
      13: r = 22'd458;
      14: r = 22'd229;
      15: r = 22'd115;
      16: r = 22'd57;
      17: r = 22'd29;
      18: r = 22'd14;
      19: r = 22'd7;
      20: r = 22'd4;
      21: r = 22'd2;
      22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/rmte_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Uses rmte_pkg for the step count.
module rmte_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [28:0] v,
  output logic [14:0] root
);

  localparam int STEPS = rmte_pkg::SQRT_STEPS;
  localparam int RW    = 31;

  logic [RW-1:0] rem_q [STEPS];
  logic [RW-1:0] res_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (30 - 2 * k);
    logic [RW-1:0] rem_in, res_in, trial;
    if (k == 0) begin : g_first
      assign rem_in = {2'b00, v};
      assign res_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end
    assign trial = res_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_q[STEPS-1][14:0];

endmodule

/* hw/rtl/rmte_cordic.sv */
// Pipelined CORDIC vectoring atan2, result in 1/128 degree saturated to +-180.
// Uses rmte_pkg for the angle table and limits.
module rmte_cordic #(
  parameter int STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rmte_pkg::OP_W-1:0]  y,
  input  logic signed [rmte_pkg::OP_W-1:0]  x,
  output logic signed [15:0]                angle
);

  localparam int W = 27;
  localparam logic signed [W-1:0] HALF_TURN = W'(180 * 65536);
  localparam logic signed [W-10:0] LIM = (W-9)'(rmte_pkg::ANG_LIMIT);

  logic signed [W-1:0] xq [STAGES+1];
  logic signed [W-1:0] yq [STAGES+1];
  logic signed [W-1:0] zq [STAGES+1];

  logic signed [W-1:0] xe, ye;
  assign xe = $signed({{(W-rmte_pkg::OP_W-8){x[rmte_pkg::OP_W-1]}}, x, 8'b0});
  assign ye = $signed({{(W-rmte_pkg::OP_W-8){y[rmte_pkg::OP_W-1]}}, y, 8'b0});

  // fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      if (xe < 0) begin
        xq[0] <= -xe;
        yq[0] <= -ye;
        zq[0] <= (ye < 0) ? -HALF_TURN : HALF_TURN;
      end else begin
        xq[0] <= xe;
        yq[0] <= ye;
        zq[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [W-1:0] ANG = $signed({{(W-22){1'b0}}, rmte_pkg::atan_q16(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (yq[i] > 0) begin
          xq[i+1] <= xq[i] + (yq[i] >>> i);
          yq[i+1] <= yq[i] - (xq[i] >>> i);
          zq[i+1] <= zq[i] + ANG;
        end else if (yq[i] < 0) begin
          xq[i+1] <= xq[i] - (yq[i] >>> i);
          yq[i+1] <= yq[i] + (xq[i] >>> i);
          zq[i+1] <= zq[i] - ANG;
        end else begin
          xq[i+1] <= xq[i];
          yq[i+1] <= yq[i];
          zq[i+1] <= zq[i];
        end
      end
    end
  end

  // round Q16 degrees to 1/128 degree, half up
  logic signed [W-1:0]  zr;
  logic signed [W-10:0] zs;
  assign zr = zq[STAGES] + W'(256);
  assign zs = zr[W-1:9];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zs > LIM)       angle <= 16'(LIM);
      else if (zs < -LIM) angle <= -16'(LIM);
      else                angle <= zs[15:0];
    end
  end

endmodule

/* hw/rtl/rotation_matrix_to_euler_degrees.sv */
// Rotation matrix (Q2.14) to roll/pitch/yaw in 1/128 degree, Z-Y-X order.
// Accepts one beat per cycle while out_stall is not holding the pipeline.
// Registers in order: input, operand select, radicand, the 16-step square root, then the
// CORDIC pipeline and the output. The whole pipeline holds while a finished beat waits on out_stall.
// Synchronous reset clears valid bits and loads the gimbal threshold with 16382.
`include "rotation_matrix_to_euler_degrees_defines.svh"
module rotation_matrix_to_euler_degrees #(
  parameter int CORDIC_STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [rmte_pkg::THR_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rmte_pkg::IN_W-1:0]  r00,
  input  logic signed [rmte_pkg::IN_W-1:0]  r01,
  input  logic signed [rmte_pkg::IN_W-1:0]  r10,
  input  logic signed [rmte_pkg::IN_W-1:0]  r11,
  input  logic signed [rmte_pkg::IN_W-1:0]  r20,
  input  logic signed [rmte_pkg::IN_W-1:0]  r21,
  input  logic signed [rmte_pkg::IN_W-1:0]  r22,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                roll_deg,
  output logic signed [14:0]                pitch_deg,
  output logic signed [15:0]                yaw_deg,
  output logic                              gimbal_locked,
  output logic                              pitch_clamped
);

  localparam int LAT  = CORDIC_STAGES + 22;
  localparam int DLY  = rmte_pkg::SQRT_STEPS + 1;
  localparam int FDLY = CORDIC_STAGES + 2;
  localparam int OPW  = rmte_pkg::OP_W;
  localparam logic signed [OPW-1:0] ONE = OPW'(rmte_pkg::ONE_Q14);
  localparam logic signed [15:0] PLIM = 16'(rmte_pkg::PITCH_LIMIT);

  logic en;
  logic [LAT-1:0] vld;
  logic [rmte_pkg::THR_W-1:0] thr;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      thr <= rmte_pkg::THR_RESET;
    end else begin
      if (en) vld <= {vld[LAT-2:0], in_valid};
      if (cfg_wr_en) thr <= cfg_wr_data;
    end
  end

  // input register
  logic signed [rmte_pkg::IN_W-1:0] a00, a01, a10, a11, a20, a21, a22;
  always_ff @(posedge clk) begin
    if (en) begin
      a00 <= r00; a01 <= r01; a10 <= r10; a11 <= r11;
      a20 <= r20; a21 <= r21; a22 <= r22;
    end
  end

  // clamp, threshold test and operand select
  logic signed [OPW-1:0] neg20;
  logic [OPW-1:0]        mag;
  rmte_pkg::side_t       s1, s2;

  always_comb begin
    neg20 = -$signed({a20[15], a20});
    mag   = a20[15] ? $unsigned(neg20) : {1'b0, $unsigned(a20)};
    s1.flags.clamped = (neg20 > ONE) || (neg20 < -ONE);
    if (neg20 > ONE)       s1.s = ONE;
    else if (neg20 < -ONE) s1.s = -ONE;
    else                   s1.s = neg20;
    s1.flags.locked = mag >= {2'b00, thr};
    s1.roll_y = $signed({a21[15], a21});
    s1.roll_x = $signed({a22[15], a22});
    if (s1.flags.locked) begin
      s1.yaw_y = -$signed({a01[15], a01});
      s1.yaw_x = $signed({a11[15], a11});
    end else begin
      s1.yaw_y = $signed({a10[15], a10});
      s1.yaw_x = $signed({a00[15], a00});
    end
  end

  always_ff @(posedge clk) begin
    if (en) s2 <= s1;
  end

  // cosine term: 2^28 - s*s, then square root
  logic signed [2*OPW-1:0] sq;
  logic [28:0]             rad;
  logic [14:0]             cos_q;
  assign sq = s2.s * s2.s;

  always_ff @(posedge clk) begin
    if (en) rad <= 29'(29'h1000_0000 - sq[28:0]);
  end

  rmte_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .v    (rad),
    .root (cos_q)
  );

  // carry the side data alongside the square root
  rmte_pkg::side_t dl [DLY];
  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= s2;
      for (int k = 1; k < DLY; k++) dl[k] <= dl[k-1];
    end
  end

  logic signed [15:0] roll_a, pitch_a, yaw_a;

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .en (en),
    .y (dl[DLY-1].s), .x ($signed({2'b00, cos_q})),
    .angle (pitch_a)
  );

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .en (en),
    .y (dl[DLY-1].roll_y), .x (dl[DLY-1].roll_x),
    .angle (roll_a)
  );

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .en (en),
    .y (dl[DLY-1].yaw_y), .x (dl[DLY-1].yaw_x),
    .angle (yaw_a)
  );

  rmte_pkg::flags_t fl [FDLY];
  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= dl[DLY-1].flags;
      for (int k = 1; k < FDLY; k++) fl[k] <= fl[k-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      roll_deg      <= fl[FDLY-1].locked ? '0 : roll_a;
      yaw_deg       <= yaw_a;
      gimbal_locked <= fl[FDLY-1].locked;
      pitch_clamped <= fl[FDLY-1].clamped;
      if (pitch_a > PLIM)       pitch_deg <= 15'(PLIM);
      else if (pitch_a < -PLIM) pitch_deg <= -15'(PLIM);
      else                      pitch_deg <= pitch_a[14:0];
    end
  end

  `RMTE_ASSERT_IMP(a_lock_roll_zero, out_valid && gimbal_locked, roll_deg == 16'sd0, "roll not zero under gimbal lock")
  `RMTE_ASSERT_IMP(a_pitch_range, out_valid, (pitch_deg <= 15'sd11520) && (pitch_deg >= -15'sd11520), "pitch out of range")
  `RMTE_ASSERT_IMP(a_stall_blocks_input, out_valid && out_stall, in_stall, "input taken while output held")

endmodule

/* test/tb_rotation_matrix_to_euler_degrees.sv */
// Self-checking testbench for rotation_matrix_to_euler_degrees: rotation matrices in, Euler
// angles out, each result checked against a CORDIC-based angle predictor in a scoreboard class.
// Depends on rmte_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_euler_degrees;

  typedef struct packed {
    logic signed [15:0] r00, r01, r10, r11, r20, r21, r22;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               locked;
    logic               clamped;
  } angles_t;

  class euler_scoreboard;
    angles_t      pending[$];
    logic [14:0]  threshold = rmte_pkg::THR_RESET;
    int           errors;
    int           matched;
    int           locked_seen;
    int           clamped_seen;

    // Q16 degrees per CORDIC step
    longint arctan_q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                               29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint vector_angle(longint y, longint x);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      // fold the left half-plane over, starting from +-180 degrees
      if (x < 0) begin
        z = (y < 0) ? -180 * 65536 : 180 * 65536;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += arctan_q16[i];
        end else if (y < 0) begin
          x -= dx; y += dy; z -= arctan_q16[i];
        end
      end
      return clip((z + 256) >>> 9, rmte_pkg::ANG_LIMIT);
    endfunction

    function longint int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_matrix(matrix_t m);
      angles_t a;
      longint  s;
      longint  c;
      longint  mag;
      s = -longint'(m.r20);
      mag = (m.r20 < 0) ? -longint'(m.r20) : longint'(m.r20);
      a.clamped = 1'b0;
      if (s > rmte_pkg::ONE_Q14) begin s = rmte_pkg::ONE_Q14; a.clamped = 1'b1; end
      if (s < -rmte_pkg::ONE_Q14) begin s = -rmte_pkg::ONE_Q14; a.clamped = 1'b1; end
      c = int_sqrt(longint'(rmte_pkg::ONE_Q14) * rmte_pkg::ONE_Q14 - s * s);
      a.pitch = 15'(clip(vector_angle(s, c), rmte_pkg::PITCH_LIMIT));
      a.locked = (mag >= longint'(threshold));
      if (!a.locked) begin
        a.roll = 16'(vector_angle(m.r21, m.r22));
        a.yaw  = 16'(vector_angle(m.r10, m.r00));
      end else begin
        a.roll = '0;
        a.yaw  = 16'(vector_angle(-longint'(m.r01), m.r11));
      end
      pending = {pending, a};
    endfunction

    function void check_angles(angles_t got);
      angles_t want;
      if (pending.size() == 0) begin
        $error("result beat with no matrix outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.roll !== want.roll) begin
        $error("roll_deg expected %0d got %0d", want.roll, got.roll); errors++;
      end
      if (got.pitch !== want.pitch) begin
        $error("pitch_deg expected %0d got %0d", want.pitch, got.pitch); errors++;
      end
      if (got.yaw !== want.yaw) begin
        $error("yaw_deg expected %0d got %0d", want.yaw, got.yaw); errors++;
      end
      if (got.locked !== want.locked) begin
        $error("gimbal_locked expected %0b got %0b", want.locked, got.locked); errors++;
      end
      if (got.clamped !== want.clamped) begin
        $error("pitch_clamped expected %0b got %0b", want.clamped, got.clamped); errors++;
      end
      matched++;
      locked_seen += want.locked;
      clamped_seen += want.clamped;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [rmte_pkg::THR_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] r00 = '0, r01 = '0, r10 = '0, r11 = '0, r20 = '0, r21 = '0, r22 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] roll_deg;
  logic signed [14:0] pitch_deg;
  logic signed [15:0] yaw_deg;
  logic gimbal_locked;
  logic pitch_clamped;

  euler_scoreboard sb = new();
  int stall_left;
  int thr_writes;

  always #2 clk = ~clk;

  rotation_matrix_to_euler_degrees dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .r00(r00), .r01(r01), .r10(r10), .r11(r11), .r20(r20), .r21(r21), .r22(r22),
    .out_valid(out_valid), .out_stall(out_stall),
    .roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
    .gimbal_locked(gimbal_locked), .pitch_clamped(pitch_clamped)
  );

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: check accepted beats, then pick the next stall value.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_angles('{roll_deg, pitch_deg, yaw_deg, gimbal_locked, pitch_clamped});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 30) begin
        stall_left <= gap_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_matrix(matrix_t m, bit idle_ok);
    int gap;
    gap = idle_ok ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {r00, r01, r10, r11, r20, r21, r22} <= m;
    do @(posedge clk); while (in_stall);
    sb.note_matrix(m);
  endtask

  task automatic write_threshold(logic [rmte_pkg::THR_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.threshold = value;
    thr_writes++;
  endtask

  function automatic logic signed [15:0] q14(real v);
    return 16'($rtoi(v * 16384.0 + ((v < 0) ? -0.5 : 0.5)));
  endfunction

  // Z-Y-X rotation built from random angles, with optional small noise.
  function automatic matrix_t random_rotation();
    real d2r, ro, pi_, ya, sr, cr, sp, cp, sy, cy;
    matrix_t m;
    int p;
    d2r = 3.14159265358979 / 180.0;
    ro = $urandom_range(0, 3600) * 0.1 - 180.0;
    ya = $urandom_range(0, 3600) * 0.1 - 180.0;
    p = $urandom_range(0, 9);
    if (p == 0) pi_ = 90.0;
    else if (p == 1) pi_ = -90.0;
    else if (p == 2) pi_ = ($urandom_range(0, 1) ? 1.0 : -1.0) * (89.0 + $urandom_range(0, 10) * 0.1);
    else pi_ = $urandom_range(0, 1800) * 0.1 - 90.0;
    sr = $sin(ro * d2r); cr = $cos(ro * d2r);
    sp = $sin(pi_ * d2r); cp = $cos(pi_ * d2r);
    sy = $sin(ya * d2r); cy = $cos(ya * d2r);
    m.r00 = q14(cy * cp);
    m.r01 = q14(cy * sp * sr - sy * cr);
    m.r10 = q14(sy * cp);
    m.r11 = q14(sy * sp * sr + cy * cr);
    m.r20 = q14(-sp);
    m.r21 = q14(cp * sr);
    m.r22 = q14(cp * cr);
    if ($urandom_range(0, 3) == 0) m.r20 = m.r20 + 16'($signed($urandom_range(0, 8)) - 4);
    return m;
  endfunction

  function automatic matrix_t random_noise();
    matrix_t m;
    m = 112'({$urandom(), $urandom(), $urandom(), $urandom()});
    return m;
  endfunction

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) begin
      send_matrix(($urandom_range(0, 99) < 75) ? random_rotation() : random_noise(),
                  (k % 64) < 48);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, extremes, asin clamp, zero vectors, left half-plane, gimbal
    send_matrix('{16384, 0, 0, 16384, 0, 0, 16384}, 1'b1);
    send_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b1);
    send_matrix('{-32768, -32768, -32768, -32768, -32768, -32768, -32768}, 1'b1);
    send_matrix('{0, 0, 0, 0, 0, 0, 0}, 1'b1);
    send_matrix('{0, 0, 0, 0, 16384, 0, 0}, 1'b1);
    send_matrix('{0, 0, 0, 0, -16384, 0, 0}, 1'b1);
    send_matrix('{0, 16384, 0, 0, 16385, 0, 0}, 1'b1);
    send_matrix('{0, -16384, 0, 0, -16385, 0, 0}, 1'b1);
    send_matrix('{0, 0, 0, 0, 16382, 0, 0}, 1'b1);
    send_matrix('{0, 0, 0, 0, 16381, 0, 0}, 1'b1);
    send_matrix('{-16384, 0, 0, -16384, 0, 0, -16384}, 1'b1);
    send_matrix('{-16384, 0, -1, 16384, 0, -1, -16384}, 1'b1);
    send_matrix('{-16384, 0, 1, 16384, 0, 1, -16384}, 1'b1);
    send_matrix('{0, 0, 16384, 0, 0, -16384, 0}, 1'b1);
    send_matrix('{0, 0, -16384, 0, 0, 16384, 0}, 1'b1);
    send_matrix('{11585, -11585, 11585, 11585, 8192, -8192, 14189}, 1'b1);
    send_matrix('{1, 0, 1, 0, -1, 1, 1}, 1'b1);
    send_matrix('{-1, 0, -1, 0, 1, -1, -1}, 1'b1);
    random_phase(100);

    write_threshold(15'd0);
    send_matrix('{0, 0, 0, 0, 0, 0, 0}, 1'b1);
    send_matrix('{0, 16384, 0, 0, 0, 5, 7}, 1'b1);
    random_phase(60);

    write_threshold(15'd16384);
    random_phase(100);

    write_threshold(15'($urandom_range(1, 16383)));
    random_phase(80);

    write_threshold(15'd8192);
    random_phase(80);

    write_threshold(rmte_pkg::THR_RESET);
    random_phase(80);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Checked %0d results over %0d threshold settings (%0d gimbal-locked, %0d clamped).",
             sb.matched, thr_writes + 1, sb.locked_seen, sb.clamped_seen);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding.", sb.pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

/* rotation_matrix_to_euler_degrees.f */
+incdir+hw/rtl
hw/rtl/rmte_pkg.sv
hw/rtl/rmte_isqrt.sv
hw/rtl/rmte_cordic.sv
hw/rtl/rotation_matrix_to_euler_degrees.sv
test/tb_rotation_matrix_to_euler_degrees.sv
